### sv/keyed_accumulate_table_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the keyed accumulate table
// Wraps concurrent checks so that they drop out of synthesis builds.
// ---------------------------------------------------------------------------
`ifndef KEYED_ACCUMULATE_TABLE_ASSERT_SVH
`define KEYED_ACCUMULATE_TABLE_ASSERT_SVH

`ifndef SYNTHESIS

`define KAT_ASSERT_NOW(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error(msg);

`define KAT_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define KAT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KAT_ASSERT_NOW(name, expr, msg)
`define KAT_ASSERT_IMP(name, ante, cons, msg)
`define KAT_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

### sv/kat_pkg.sv
// ---------------------------------------------------------------------------
// Keyed accumulate table package
// Sizes, entry layout, cell control and status codes shared by the block.
// ---------------------------------------------------------------------------
package kat_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int CODE_W      = 64;
  localparam int CITY_W      = 64;
  localparam int DAY_W       = 5;
  localparam int MONTH_W     = 4;
  localparam int YEAR_W      = 14;
  localparam int DATE_W      = DAY_W + MONTH_W + YEAR_W;
  localparam int AMOUNT_W    = 31;
  localparam int PPL_IN_W    = 16;
  localparam int COST_W      = 40;
  localparam int PEOPLE_W    = 32;
  localparam int STATUS_W    = 3;
  localparam int SLOT_W      = 6;
  localparam int COUNT_W     = 7;

  localparam logic [COST_W-1:0]   COST_MAX   = {1'b0, {(COST_W - 1){1'b1}}};
  localparam logic [COST_W-1:0]   COST_MIN   = {1'b1, {(COST_W - 1){1'b0}}};
  localparam logic [PEOPLE_W-1:0] PEOPLE_MAX = {1'b0, {(PEOPLE_W - 1){1'b1}}};
  localparam logic [PEOPLE_W-1:0] PEOPLE_MIN = {1'b1, {(PEOPLE_W - 1){1'b0}}};

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic [CODE_W-1:0]   code;
    logic [CITY_W-1:0]   city;
    logic [DATE_W-1:0]   date;
    logic [COST_W-1:0]   cost;
    logic [PEOPLE_W-1:0] people;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_SHIFT,
    CELL_WRITE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    idx_t     target;
    entry_t   wr_entry;
  } cell_ctl_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_INSERTED   = 3'd0,
    STAT_MERGED     = 3'd1,
    STAT_REDUCED    = 3'd2,
    STAT_REMOVED    = 3'd3,
    STAT_NOT_FOUND  = 3'd4,
    STAT_TABLE_FULL = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_CALC,
    S_APPLY,
    S_DONE
  } state_t;

endpackage

### sv/kat_item_if.sv
// ---------------------------------------------------------------------------
// Item channel
// Valid/ready channel that carries one table operation per beat.
// ---------------------------------------------------------------------------
interface kat_item_if;

  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [kat_pkg::CODE_W-1:0]    code_key;
  logic [kat_pkg::CITY_W-1:0]    city_key;
  logic [kat_pkg::DAY_W-1:0]     day;
  logic [kat_pkg::MONTH_W-1:0]   month;
  logic [kat_pkg::YEAR_W-1:0]    year;
  logic [kat_pkg::AMOUNT_W-1:0]  amount;
  logic [kat_pkg::PPL_IN_W-1:0]  people;

  modport source (
    output valid, action, code_key, city_key, day, month, year, amount, people,
    input  ready
  );

  modport sink (
    input  valid, action, code_key, city_key, day, month, year, amount, people,
    output ready
  );

endinterface

### sv/kat_result_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one operation outcome per beat.
// ---------------------------------------------------------------------------
interface kat_result_if;

  logic                                valid;
  logic                                ready;
  logic [kat_pkg::STATUS_W-1:0]        status;
  logic [kat_pkg::SLOT_W-1:0]          slot;
  logic [kat_pkg::COUNT_W-1:0]         entry_count;
  logic signed [kat_pkg::COST_W-1:0]   cost_total;
  logic signed [kat_pkg::PEOPLE_W-1:0] people_total;

  modport source (
    output valid, status, slot, entry_count, cost_total, people_total,
    input  ready
  );

  modport sink (
    input  valid, status, slot, entry_count, cost_total, people_total,
    output ready
  );

endinterface

### sv/keyed_accumulate_table.sv
// ---------------------------------------------------------------------------
// Keyed accumulate table
// Ordered table of keyed cost and people totals kept in a ring of cells.
// ---------------------------------------------------------------------------
//   Channel  Direction  Beat
//   item     in         action, code, city, date, amount and people
//   result   out        status, slot, entry count, cost and people totals
//
// After acceptance, an item's result beat follows one full turn of the cell
// ring past the head comparator, then the totals update and the table write.
// Reset clears the entry count and the handshake state.
// The next item is accepted once the previous result sits in the output
// register, even while that beat still waits for the sink.
// ---------------------------------------------------------------------------
`include "keyed_accumulate_table_assert.svh"

module keyed_accumulate_table (
  input  logic         clk,
  input  logic         rst,
  kat_item_if.sink     item,
  kat_result_if.source result
);

  kat_pkg::entry_t    cells [kat_pkg::MAX_ENTRIES];
  kat_pkg::cell_ctl_t cell_ctl;
  kat_pkg::cnt_t      count;

  kat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .result   (result),
    .head     (cells[0]),
    .cell_ctl (cell_ctl),
    .count    (count)
  );

  for (genvar i = 0; i < kat_pkg::MAX_ENTRIES; i++) begin : g_cell
    kat_cell u_cell (
      .clk      (clk),
      .index    (kat_pkg::idx_t'(i)),
      .ctl      (cell_ctl),
      .neighbor (cells[(i + 1) % kat_pkg::MAX_ENTRIES]),
      .entry    (cells[i])
    );
  end

  `KAT_ASSERT_NOW(a_count_bound, count <= kat_pkg::cnt_t'(kat_pkg::MAX_ENTRIES), "entry count above table size")
  `KAT_ASSERT_IMP(a_write_range, cell_ctl.op == kat_pkg::CELL_WRITE, kat_pkg::cnt_t'(cell_ctl.target) <= count, "write beyond the end of the table")
  `KAT_ASSERT_IMP(a_shift_range, cell_ctl.op == kat_pkg::CELL_SHIFT, kat_pkg::cnt_t'(cell_ctl.target) < count, "removal outside the filled entries")
  `KAT_ASSERT_IMP(a_count_step, !$past(rst) && count != $past(count), count == $past(count) + 1 || count + 1 == $past(count), "entry count moved by more than one")
  `KAT_ASSERT_NEXT(a_search_start, item.valid && item.ready, cell_ctl.op == kat_pkg::CELL_ROTATE, "accepted item did not start the ring search")

endmodule

### sv/kat_cell.sv
// ---------------------------------------------------------------------------
// Table cell
// Holds one table entry; rotates, shifts down or loads under ring control.
// ---------------------------------------------------------------------------
module kat_cell (
  input  logic               clk,
  input  kat_pkg::idx_t      index,
  input  kat_pkg::cell_ctl_t ctl,
  input  kat_pkg::entry_t    neighbor,
  output kat_pkg::entry_t    entry
);

  kat_pkg::entry_t entry_next;

  always_comb begin
    entry_next = entry;
    case (ctl.op)
      kat_pkg::CELL_HOLD: begin
        entry_next = entry;
      end
      kat_pkg::CELL_ROTATE: begin
        entry_next = neighbor;
      end
      kat_pkg::CELL_SHIFT: begin
        if (index >= ctl.target) begin
          entry_next = neighbor;
        end
      end
      kat_pkg::CELL_WRITE: begin
        if (index == ctl.target) begin
          entry_next = ctl.wr_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### sv/kat_ctrl.sv
// ---------------------------------------------------------------------------
// Table controller
// Sequences the ring search, updates the totals and drives the result beat.
// ---------------------------------------------------------------------------
module kat_ctrl (
  input  logic               clk,
  input  logic               rst,
  kat_item_if.sink           item,
  kat_result_if.source       result,
  input  kat_pkg::entry_t    head,
  output kat_pkg::cell_ctl_t cell_ctl,
  output kat_pkg::cnt_t      count
);

  kat_pkg::state_t state, state_next;

  kat_pkg::idx_t   step;
  kat_pkg::idx_t   hit;
  logic            found;
  kat_pkg::cnt_t   used_count;
  kat_pkg::cnt_t   used_count_next;

  logic                          action_r;
  logic [kat_pkg::CODE_W-1:0]    req_code;
  logic [kat_pkg::CITY_W-1:0]    req_city;
  logic [kat_pkg::DATE_W-1:0]    req_date;
  logic [kat_pkg::AMOUNT_W-1:0]  req_amount;
  logic [kat_pkg::PPL_IN_W-1:0]  req_people;

  logic [kat_pkg::COST_W-1:0]    hit_cost;
  logic [kat_pkg::PEOPLE_W-1:0]  hit_people;
  logic [kat_pkg::COST_W-1:0]    new_cost;
  logic [kat_pkg::PEOPLE_W-1:0]  new_people;

  kat_pkg::status_t              pend_status;
  kat_pkg::slot_t                pend_slot;
  kat_pkg::count_t               pend_count;
  logic [kat_pkg::COST_W-1:0]    pend_cost;
  logic [kat_pkg::PEOPLE_W-1:0]  pend_people;

  logic                          out_valid;
  kat_pkg::status_t              out_status;
  kat_pkg::slot_t                out_slot;
  kat_pkg::count_t               out_count;
  logic [kat_pkg::COST_W-1:0]    out_cost;
  logic [kat_pkg::PEOPLE_W-1:0]  out_people;

  logic item_take;
  logic head_match;
  logic last_step;
  logic table_full;
  logic drop_entry;
  logic report_zero;
  logic out_load;

  logic [kat_pkg::COST_W:0]      amount_ext;
  logic [kat_pkg::COST_W:0]      cost_sum;
  logic [kat_pkg::COST_W-1:0]    cost_sat;
  logic [kat_pkg::PEOPLE_W:0]    people_ext;
  logic [kat_pkg::PEOPLE_W:0]    people_sum;
  logic [kat_pkg::PEOPLE_W-1:0]  people_sat;

  kat_pkg::status_t              apply_status;
  kat_pkg::slot_t                apply_slot;

  assign item_take  = item.valid && item.ready;
  assign last_step  = step == kat_pkg::idx_t'(kat_pkg::MAX_ENTRIES - 1);
  assign table_full = used_count == kat_pkg::cnt_t'(kat_pkg::MAX_ENTRIES);
  assign head_match = !found && (kat_pkg::cnt_t'(step) < used_count) &&
                      head.code == req_code && head.city == req_city &&
                      head.date == req_date;
  assign drop_entry = new_cost[kat_pkg::COST_W-1] || new_cost == '0 ||
                      new_people[kat_pkg::PEOPLE_W-1] || new_people == '0;
  assign out_load   = (state == kat_pkg::S_DONE) && (!out_valid || result.ready);
  assign count      = used_count;

  // Totals update: one widened add or subtract per total, then saturate.
  always_comb begin
    amount_ext = {{(kat_pkg::COST_W + 1 - kat_pkg::AMOUNT_W){1'b0}}, req_amount};
    people_ext = {{(kat_pkg::PEOPLE_W + 1 - kat_pkg::PPL_IN_W){1'b0}}, req_people};
    if (action_r) begin
      cost_sum   = {hit_cost[kat_pkg::COST_W-1], hit_cost} - amount_ext;
      people_sum = {hit_people[kat_pkg::PEOPLE_W-1], hit_people} - people_ext;
    end else begin
      cost_sum   = {hit_cost[kat_pkg::COST_W-1], hit_cost} + amount_ext;
      people_sum = {hit_people[kat_pkg::PEOPLE_W-1], hit_people} + people_ext;
    end
    if (cost_sum[kat_pkg::COST_W] != cost_sum[kat_pkg::COST_W-1]) begin
      cost_sat = cost_sum[kat_pkg::COST_W] ? kat_pkg::COST_MIN : kat_pkg::COST_MAX;
    end else begin
      cost_sat = cost_sum[kat_pkg::COST_W-1:0];
    end
    if (people_sum[kat_pkg::PEOPLE_W] != people_sum[kat_pkg::PEOPLE_W-1]) begin
      people_sat = people_sum[kat_pkg::PEOPLE_W] ? kat_pkg::PEOPLE_MIN : kat_pkg::PEOPLE_MAX;
    end else begin
      people_sat = people_sum[kat_pkg::PEOPLE_W-1:0];
    end
  end

  always_comb begin
    apply_status    = kat_pkg::STAT_NOT_FOUND;
    used_count_next = used_count;
    if (!action_r) begin
      if (found) begin
        apply_status = kat_pkg::STAT_MERGED;
      end else if (!table_full) begin
        apply_status    = kat_pkg::STAT_INSERTED;
        used_count_next = kat_pkg::cnt_t'(used_count + 1'b1);
      end else begin
        apply_status = kat_pkg::STAT_TABLE_FULL;
      end
    end else if (found) begin
      if (drop_entry) begin
        apply_status    = kat_pkg::STAT_REMOVED;
        used_count_next = kat_pkg::cnt_t'(used_count - 1'b1);
      end else begin
        apply_status = kat_pkg::STAT_REDUCED;
      end
    end
    report_zero = !found && (action_r || table_full);
    apply_slot  = found ? kat_pkg::slot_t'(hit) : kat_pkg::slot_t'(used_count);
    if (report_zero) begin
      apply_slot = '0;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      kat_pkg::S_IDLE: begin
        if (item_take) begin
          state_next = kat_pkg::S_SEARCH;
        end
      end
      kat_pkg::S_SEARCH: begin
        if (last_step) begin
          state_next = kat_pkg::S_CALC;
        end
      end
      kat_pkg::S_CALC: begin
        state_next = kat_pkg::S_APPLY;
      end
      kat_pkg::S_APPLY: begin
        state_next = kat_pkg::S_DONE;
      end
      kat_pkg::S_DONE: begin
        if (out_load) begin
          state_next = kat_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = kat_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    item.ready               = 1'b0;
    cell_ctl.op              = kat_pkg::CELL_HOLD;
    cell_ctl.target          = hit;
    cell_ctl.wr_entry.code   = req_code;
    cell_ctl.wr_entry.city   = req_city;
    cell_ctl.wr_entry.date   = req_date;
    cell_ctl.wr_entry.cost   = new_cost;
    cell_ctl.wr_entry.people = new_people;
    case (state)
      kat_pkg::S_IDLE: begin
        item.ready = 1'b1;
      end
      kat_pkg::S_SEARCH: begin
        cell_ctl.op = kat_pkg::CELL_ROTATE;
      end
      kat_pkg::S_APPLY: begin
        case (apply_status)
          kat_pkg::STAT_INSERTED: begin
            cell_ctl.op     = kat_pkg::CELL_WRITE;
            cell_ctl.target = kat_pkg::idx_t'(used_count);
          end
          kat_pkg::STAT_MERGED, kat_pkg::STAT_REDUCED: begin
            cell_ctl.op = kat_pkg::CELL_WRITE;
          end
          kat_pkg::STAT_REMOVED: begin
            cell_ctl.op = kat_pkg::CELL_SHIFT;
          end
          default: begin
            cell_ctl.op = kat_pkg::CELL_HOLD;
          end
        endcase
      end
      default: begin
        cell_ctl.op = kat_pkg::CELL_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= kat_pkg::S_IDLE;
      step       <= '0;
      found      <= 1'b0;
      used_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (item_take) begin
        step  <= '0;
        found <= 1'b0;
      end else if (state == kat_pkg::S_SEARCH) begin
        step <= kat_pkg::idx_t'(step + 1'b1);
        if (head_match) begin
          found <= 1'b1;
        end
      end
      if (state == kat_pkg::S_APPLY) begin
        used_count <= used_count_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      action_r   <= item.action;
      req_code   <= item.code_key;
      req_city   <= item.city_key;
      req_date   <= {item.year, item.month, item.day};
      req_amount <= item.amount;
      req_people <= item.people;
    end
    if (state == kat_pkg::S_SEARCH && head_match) begin
      hit        <= step;
      hit_cost   <= head.cost;
      hit_people <= head.people;
    end
    if (state == kat_pkg::S_CALC) begin
      if (found) begin
        new_cost   <= cost_sat;
        new_people <= people_sat;
      end else begin
        new_cost   <= {{(kat_pkg::COST_W - kat_pkg::AMOUNT_W){1'b0}}, req_amount};
        new_people <= {{(kat_pkg::PEOPLE_W - kat_pkg::PPL_IN_W){1'b0}}, req_people};
      end
    end
    if (state == kat_pkg::S_APPLY) begin
      pend_status <= apply_status;
      pend_slot   <= apply_slot;
      pend_count  <= kat_pkg::count_t'(used_count_next);
      pend_cost   <= report_zero ? '0 : new_cost;
      pend_people <= report_zero ? '0 : new_people;
    end
    if (out_load) begin
      out_status <= pend_status;
      out_slot   <= pend_slot;
      out_count  <= pend_count;
      out_cost   <= pend_cost;
      out_people <= pend_people;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.slot         = out_slot;
  assign result.entry_count  = out_count;
  assign result.cost_total   = out_cost;
  assign result.people_total = out_people;

endmodule

### test/tb.sv
// ---------------------------------------------------------------------------
// Keyed accumulate table testbench
// Sends add and subtract beats through the item channel and predicts every
// outcome with a behavioral copy of the ordered table. Each result beat is
// checked field by field against the oldest prediction. Stimulus covers
// directed corner cases, a full table, cost saturation and random traffic,
// with idle bursts and back-pressure on both channels.
// ---------------------------------------------------------------------------
module tb;
  import kat_pkg::*;

  localparam int     LATENCY     = MAX_ENTRIES + 4;
  localparam int     QUIET_LIMIT = 2000;
  localparam int     LONG_HOLD   = 400;
  localparam int     POOL_SIZE   = 96;
  localparam longint COST_HI     = longint'($signed(COST_MAX));
  localparam longint COST_LO     = longint'($signed(COST_MIN));
  localparam longint PEOPLE_HI   = longint'($signed(PEOPLE_MAX));
  localparam longint PEOPLE_LO   = longint'($signed(PEOPLE_MIN));
  localparam logic [AMOUNT_W-1:0] AMOUNT_TOP = '1;
  localparam logic [PPL_IN_W-1:0] PEOPLE_TOP = '1;

  typedef enum logic {
    ACT_ADD = 1'b0,
    ACT_SUB = 1'b1
  } action_t;

  typedef struct {
    logic [CODE_W-1:0]  code;
    logic [CITY_W-1:0]  city;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } key_t;

  typedef struct {
    action_t             action;
    key_t                key;
    logic [AMOUNT_W-1:0] amount;
    logic [PPL_IN_W-1:0] people;
  } item_t;

  typedef struct {
    status_t                    status;
    slot_t                      slot;
    count_t                     count;
    logic signed [COST_W-1:0]   cost;
    logic signed [PEOPLE_W-1:0] people;
  } outcome_t;

  class ledger_board;
    key_t                       keys[MAX_ENTRIES];
    logic signed [COST_W-1:0]   costs[MAX_ENTRIES];
    logic signed [PEOPLE_W-1:0] heads[MAX_ENTRIES];
    int                         used;
    outcome_t                   due_outcomes[$];
    int                         items_seen;
    int                         results_seen;
    int                         failures;
    int                         status_tally[6];

    function new();
      used = 0;
      items_seen = 0;
      results_seen = 0;
      failures = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function bit same_key(key_t a, key_t b);
      return a.code == b.code && a.city == b.city && a.day == b.day &&
             a.month == b.month && a.year == b.year;
    endfunction

    function outcome_t book_item(item_t it);
      outcome_t o;
      int       hit;
      longint   c;
      longint   p;
      hit = -1;
      for (int i = 0; i < used; i++) begin
        if (hit < 0 && same_key(keys[i], it.key)) hit = i;
      end
      o.status = STAT_NOT_FOUND;
      o.slot   = '0;
      o.cost   = '0;
      o.people = '0;
      if (it.action == ACT_ADD) begin
        if (hit >= 0) begin
          c = clamp(longint'(costs[hit]) + longint'(it.amount), COST_LO, COST_HI);
          p = clamp(longint'(heads[hit]) + longint'(it.people), PEOPLE_LO, PEOPLE_HI);
          costs[hit] = COST_W'(c);
          heads[hit] = PEOPLE_W'(p);
          o.status = STAT_MERGED;
          o.slot   = slot_t'(hit);
          o.cost   = costs[hit];
          o.people = heads[hit];
        end else if (used < MAX_ENTRIES) begin
          keys[used]  = it.key;
          costs[used] = it.amount;
          heads[used] = it.people;
          o.status = STAT_INSERTED;
          o.slot   = slot_t'(used);
          o.cost   = costs[used];
          o.people = heads[used];
          used++;
        end else begin
          o.status = STAT_TABLE_FULL;
        end
      end else if (hit >= 0) begin
        c = clamp(longint'(costs[hit]) - longint'(it.amount), COST_LO, COST_HI);
        p = clamp(longint'(heads[hit]) - longint'(it.people), PEOPLE_LO, PEOPLE_HI);
        o.slot   = slot_t'(hit);
        o.cost   = COST_W'(c);
        o.people = PEOPLE_W'(p);
        if (c <= 0 || p <= 0) begin
          for (int i = hit; i + 1 < used; i++) begin
            keys[i]  = keys[i + 1];
            costs[i] = costs[i + 1];
            heads[i] = heads[i + 1];
          end
          used--;
          o.status = STAT_REMOVED;
        end else begin
          costs[hit] = o.cost;
          heads[hit] = o.people;
          o.status = STAT_REDUCED;
        end
      end
      o.count = count_t'(used);
      return o;
    endfunction

    function void note_item(item_t it);
      due_outcomes.push_back(book_item(it));
      items_seen++;
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      results_seen++;
      if (due_outcomes.size() == 0) begin
        $error("result beat with status %0d arrived with nothing pending", got.status);
        failures++;
        return;
      end
      want = due_outcomes.pop_front();
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        failures++;
      end
      if (got.slot !== want.slot) begin
        $error("slot expected %0d actual %0d", want.slot, got.slot);
        failures++;
      end
      if (got.count !== want.count) begin
        $error("entry_count expected %0d actual %0d", want.count, got.count);
        failures++;
      end
      if (got.cost !== want.cost) begin
        $error("cost_total expected %0d actual %0d", want.cost, got.cost);
        failures++;
      end
      if (got.people !== want.people) begin
        $error("people_total expected %0d actual %0d", want.people, got.people);
        failures++;
      end
      status_tally[int'(want.status)]++;
    endfunction
  endclass

  logic         clk;
  logic         rst;
  kat_item_if   item_ch();
  kat_result_if result_ch();

  keyed_accumulate_table u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  ledger_board sb = new();
  key_t        key_pool[POOL_SIZE];
  int          src_idle_pct = 0;
  int          snk_idle_pct = 0;
  bit          long_hold_req = 1'b0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic key_t random_key();
    key_t k;
    k.code  = {$urandom, $urandom};
    k.city  = {$urandom, $urandom};
    k.day   = DAY_W'($urandom_range(31, 1));
    k.month = MONTH_W'($urandom_range(12, 1));
    k.year  = YEAR_W'($urandom_range(9999, 0));
    return k;
  endfunction

  function automatic item_t make_item(action_t act, key_t k, logic [AMOUNT_W-1:0] amt,
                                      logic [PPL_IN_W-1:0] ppl);
    item_t it;
    it.action = act;
    it.key    = k;
    it.amount = amt;
    it.people = ppl;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t it;
    int    pick;
    it.action = ($urandom_range(99) < 55) ? ACT_ADD : ACT_SUB;
    pick = $urandom_range(99);
    if (it.action == ACT_SUB && sb.used > 0 && pick < 80) begin
      it.key = sb.keys[$urandom_range(sb.used - 1)];
    end else if (pick < 92) begin
      it.key = key_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      it.key = random_key();
    end
    pick = $urandom_range(9);
    if (pick == 0) it.amount = '0;
    else if (pick == 1) it.amount = AMOUNT_TOP;
    else if (pick < 6) it.amount = AMOUNT_W'($urandom_range(5000, 1));
    else it.amount = AMOUNT_W'($urandom);
    pick = $urandom_range(19);
    if (pick < 2) it.people = '0;
    else if (pick == 2) it.people = PEOPLE_TOP;
    else if (pick < 12) it.people = PPL_IN_W'($urandom_range(50, 1));
    else it.people = PPL_IN_W'($urandom);
    return it;
  endfunction

  task automatic offer_item(input item_t it);
    int waited;
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      item_ch.valid <= 1'b0;
      if ($urandom_range(1) == 1) begin
        waited = 0;
        do begin
          @(posedge clk);
          waited++;
        end while (!item_ch.ready && waited < 2 * LATENCY);
      end
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.action   <= it.action;
    item_ch.code_key <= it.key.code;
    item_ch.city_key <= it.key.city;
    item_ch.day      <= it.key.day;
    item_ch.month    <= it.key.month;
    item_ch.year     <= it.key.year;
    item_ch.amount   <= it.amount;
    item_ch.people   <= it.people;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.due_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int count, input int src_pct, input int snk_pct);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (count) offer_item(random_item());
  endtask

  always @(posedge clk) begin
    item_t    seen_item;
    outcome_t got;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        seen_item.action    = action_t'(item_ch.action);
        seen_item.key.code  = item_ch.code_key;
        seen_item.key.city  = item_ch.city_key;
        seen_item.key.day   = item_ch.day;
        seen_item.key.month = item_ch.month;
        seen_item.key.year  = item_ch.year;
        seen_item.amount    = item_ch.amount;
        seen_item.people    = item_ch.people;
        sb.note_item(seen_item);
      end
      if (result_ch.valid && result_ch.ready) begin
        got.status = status_t'(result_ch.status);
        got.slot   = result_ch.slot;
        got.count  = result_ch.entry_count;
        got.cost   = result_ch.cost_total;
        got.people = result_ch.people_total;
        sb.check_outcome(got);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $error("no beat moved for %0d cycles", QUIET_LIMIT);
      $display("[keyed_accumulate_table] ERROR");
      $finish;
    end
  end

  initial begin
    result_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (snk_idle_pct > 0 && $urandom_range(99) < snk_idle_pct) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(5, 1)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  initial begin
    key_t ka;
    key_t kb;
    key_t kc;
    key_t kd;
    key_t twin;
    key_t first_key;
    key_t last_key;
    int   n;
    rst              <= 1'b1;
    item_ch.valid    <= 1'b0;
    item_ch.action   <= 1'b0;
    item_ch.code_key <= '0;
    item_ch.city_key <= '0;
    item_ch.day      <= '0;
    item_ch.month    <= '0;
    item_ch.year     <= '0;
    item_ch.amount   <= '0;
    item_ch.people   <= '0;

    // Part of the pool are near twins of earlier keys, differing in one field.
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i >= 16 && $urandom_range(2) == 0) begin
        key_pool[i] = key_pool[$urandom_range(i - 1)];
        case ($urandom_range(2))
          0: key_pool[i].code[$urandom_range(CODE_W - 1)] ^= 1'b1;
          1: key_pool[i].city[$urandom_range(CITY_W - 1)] ^= 1'b1;
          default: key_pool[i].day = DAY_W'((key_pool[i].day % 31) + 1);
        endcase
      end else begin
        key_pool[i] = random_key();
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    ka = random_key();
    kb.code  = '1;
    kb.city  = '1;
    kb.day   = 5'd31;
    kb.month = 4'd12;
    kb.year  = 14'd9999;
    kc.code  = '0;
    kc.city  = '0;
    kc.day   = 5'd1;
    kc.month = 4'd1;
    kc.year  = 14'd0;
    offer_item(make_item(ACT_SUB, ka, 31'd10, 16'd10));
    offer_item(make_item(ACT_ADD, ka, '0, '0));
    offer_item(make_item(ACT_ADD, ka, AMOUNT_TOP, PEOPLE_TOP));
    offer_item(make_item(ACT_ADD, kb, 31'd1000, 16'd20));
    offer_item(make_item(ACT_ADD, kc, AMOUNT_TOP, 16'd1));
    twin = kb;
    twin.code[CODE_W-1] = 1'b0;
    offer_item(make_item(ACT_ADD, twin, 31'd3, 16'd3));
    twin = kb;
    twin.city[0] = 1'b0;
    offer_item(make_item(ACT_ADD, twin, 31'd4, 16'd4));
    twin = kb;
    twin.year[YEAR_W-1] = 1'b0;
    offer_item(make_item(ACT_ADD, twin, 31'd5, 16'd5));
    twin = kb;
    twin.month[MONTH_W-1] = 1'b0;
    offer_item(make_item(ACT_ADD, twin, 31'd6, 16'd6));
    offer_item(make_item(ACT_SUB, kb, 31'd100, 16'd5));
    offer_item(make_item(ACT_ADD, kb, 31'd7, 16'd0));
    offer_item(make_item(ACT_SUB, kb, 31'd1, 16'd15));
    offer_item(make_item(ACT_SUB, kb, 31'd1, 16'd1));
    kd = random_key();
    offer_item(make_item(ACT_ADD, kd, '0, '0));
    offer_item(make_item(ACT_SUB, kd, '0, '0));
    offer_item(make_item(ACT_SUB, kc, AMOUNT_TOP, '0));
    kd = random_key();
    offer_item(make_item(ACT_ADD, kd, 31'd5, 16'd3));
    offer_item(make_item(ACT_SUB, kd, 31'd1000, 16'd1));
    offer_item(make_item(ACT_SUB, ka, 31'd1, 16'd1));
    drain_results();

    n = sb.used;
    repeat (MAX_ENTRIES - n + 3) begin
      offer_item(make_item(ACT_ADD, random_key(), AMOUNT_W'($urandom),
                           PPL_IN_W'($urandom_range(1000, 1))));
    end
    drain_results();
    first_key = sb.keys[0];
    last_key  = sb.keys[MAX_ENTRIES-1];
    offer_item(make_item(ACT_ADD, last_key, 31'd5, 16'd5));
    offer_item(make_item(ACT_SUB, last_key, '0, PEOPLE_TOP));
    offer_item(make_item(ACT_SUB, first_key, '0, PEOPLE_TOP));
    offer_item(make_item(ACT_ADD, random_key(), 31'd1, 16'd1));
    drain_results();

    ka = sb.keys[0];
    src_idle_pct = 10;
    snk_idle_pct = 10;
    repeat (260) offer_item(make_item(ACT_ADD, ka, AMOUNT_TOP, PEOPLE_TOP));
    offer_item(make_item(ACT_SUB, ka, 31'd1, 16'd1));
    drain_results();

    long_hold_req = 1'b1;
    run_random(220, 20, 20);
    drain_results();
    run_random(260, 0, 0);
    run_random(260, 40, 40);
    drain_results();
    run_random(220, 0, 0);
    drain_results();
    repeat (2 * LATENCY) @(posedge clk);

    if (sb.due_outcomes.size() != 0) begin
      $error("%0d predicted results never arrived", sb.due_outcomes.size());
      sb.failures++;
    end
    $display("Run sent %0d items and checked %0d result beats.", sb.items_seen,
             sb.results_seen);
    $display("Outcomes: %0d inserted, %0d merged, %0d reduced, %0d removed, %0d not found, %0d full.",
             sb.status_tally[int'(STAT_INSERTED)], sb.status_tally[int'(STAT_MERGED)],
             sb.status_tally[int'(STAT_REDUCED)], sb.status_tally[int'(STAT_REMOVED)],
             sb.status_tally[int'(STAT_NOT_FOUND)], sb.status_tally[int'(STAT_TABLE_FULL)]);
    if (sb.failures == 0) begin
      $display("[keyed_accumulate_table] OK");
    end else begin
      $display("[keyed_accumulate_table] ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+sv
sv/kat_pkg.sv
sv/kat_item_if.sv
sv/kat_result_if.sv
sv/kat_cell.sv
sv/kat_ctrl.sv
sv/keyed_accumulate_table.sv
test/tb.sv
